/* hdl/gdr_pkg.sv */
package gdr_pkg;

  // Grid and stack sizes.
  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int STACK_DEPTH = 128;
  localparam int CELLS       = MAX_ROWS * MAX_COLS;

  // Field widths.
  localparam int ROW_W     = 5;
  localparam int COL_W     = 5;
  localparam int DIM_W     = 6;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int TOT_W     = 2 * DIM_W;

  localparam int IDX_W   = $clog2(CELLS);
  localparam int SP_W    = $clog2(STACK_DEPTH + 1);
  localparam int SADDR_W = $clog2(STACK_DEPTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_ROW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_COL   = 3'd5;

  // Neighbor visiting order.
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHK_S,
    S_CHK_E,
    S_CHK_D,
    S_POP,
    S_FETCH,
    S_VISIT,
    S_NB_RD,
    S_NB_CHK,
    S_MARK
  } gdr_state_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } gdr_pos_t;

  typedef struct packed {
    logic blocked;
    logic visited;
  } gdr_cell_t;

  typedef struct packed {
    logic load_cell;
    logic search_init;
    logic rd_start;
    logic rd_end;
    logic push_start;
    logic pop;
    logic latch_cur;
    logic nb_first;
    logic nb_next;
    logic nb_rd;
    logic nb_push;
    logic mark;
    logic finish;
    logic finish_reach;
  } gdr_cmd_t;

  typedef struct packed {
    logic last_cell;
    logic out_busy;
    logic in_range;
    logic ends_blocked;
    logic stack_empty;
    logic cur_visited;
    logic cur_is_end;
    logic nb_ok;
    logic nb_last;
  } gdr_status_t;

  // Row-major cell index of a position in a grid with the given column count.
  function automatic logic [IDX_W-1:0] cell_index(gdr_pos_t pos, logic [DIM_W-1:0] cols);
    logic [ROW_W+DIM_W-1:0] full;
    full = ({{DIM_W{1'b0}}, pos.row} * {{ROW_W{1'b0}}, cols})
         + {{(ROW_W+DIM_W-COL_W){1'b0}}, pos.col};
    return full[IDX_W-1:0];
  endfunction

endpackage

/* hdl/grid_dfs_reachability_top.sv */
// Map load: one cell beat per cycle, but the last cell waits while a result is pending;
// its beat starts the search. Search: start and end checks, then for each popped cell
// pop, fetch, check, and unless visited or the end, neighbor reads and a mark.
// The result beat is valid the cycle after the search ends; input is held off meanwhile.
// Reset: configuration returns to a 32 x 32 grid with start and end at cell 0;
// memories are not cleared, as visited marks are cleared while the cells load.
module grid_dfs_reachability_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cell_blocked,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          reachable,
  output logic                          stack_overflow,
  input  logic                          cfg_write,
  input  logic [gdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gdr_pkg::CFG_W-1:0]     cfg_data
);
  import gdr_pkg::*;

  // The controller sequences the load and the depth-first search; the datapath
  // holds configuration, the cell memory (blocked and visited bits per cell),
  // the search stack of row and column pairs, and the result register.
  gdr_cmd_t    cmd;
  gdr_status_t st;

  gdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The result register lets the next map start loading while a result beat
  // still waits; only the beat that completes the next map is held back.
  gdr_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cell_blocked   (cell_blocked),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .reachable      (reachable),
    .stack_overflow (stack_overflow),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .st             (st)
  );

`ifndef SYNTHESIS
  // A search never finishes onto a result that has not been taken.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_valid)
    else $error("search finished while a result beat was pending");

  // Pops only happen with something on the stack.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !st.stack_empty)
    else $error("pop from an empty search stack");

  // Once the last cell is taken, input stays held off while the search runs.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && st.last_cell) |=> !in_ready)
    else $error("input accepted during a search");
`endif

endmodule

/* hdl/gdr_ctrl.sv */
module gdr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gdr_pkg::gdr_status_t st,
  output gdr_pkg::gdr_cmd_t    cmd
);
  import gdr_pkg::*;

  gdr_state_t state;
  gdr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_valid && in_ready && st.last_cell) state_next = S_CHK_S;
      end
      S_CHK_S: begin
        state_next = st.in_range ? S_CHK_E : S_LOAD;
      end
      S_CHK_E: begin
        state_next = S_CHK_D;
      end
      S_CHK_D: begin
        state_next = st.ends_blocked ? S_LOAD : S_POP;
      end
      S_POP: begin
        state_next = st.stack_empty ? S_LOAD : S_FETCH;
      end
      S_FETCH: begin
        state_next = S_VISIT;
      end
      S_VISIT: begin
        priority if (st.cur_visited) state_next = S_POP;
        else if (st.cur_is_end)      state_next = S_LOAD;
        else                         state_next = S_NB_RD;
      end
      S_NB_RD: begin
        priority if (st.nb_ok) state_next = S_NB_CHK;
        else if (st.nb_last)   state_next = S_MARK;
        else                   state_next = S_NB_RD;
      end
      S_NB_CHK: begin
        state_next = st.nb_last ? S_MARK : S_NB_RD;
      end
      S_MARK: begin
        state_next = S_POP;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ready        = !(st.last_cell && st.out_busy);
        cmd.load_cell   = in_valid && in_ready;
        cmd.search_init = in_valid && in_ready && st.last_cell;
      end
      S_CHK_S: begin
        cmd.rd_start = 1'b1;
        cmd.finish   = !st.in_range;
      end
      S_CHK_E: begin
        cmd.rd_end = 1'b1;
      end
      S_CHK_D: begin
        cmd.finish     = st.ends_blocked;
        cmd.push_start = !st.ends_blocked;
      end
      S_POP: begin
        cmd.finish = st.stack_empty;
        cmd.pop    = !st.stack_empty;
      end
      S_FETCH: begin
        cmd.latch_cur = 1'b1;
      end
      S_VISIT: begin
        cmd.finish       = !st.cur_visited && st.cur_is_end;
        cmd.finish_reach = 1'b1;
        cmd.nb_first     = !st.cur_visited && !st.cur_is_end;
      end
      S_NB_RD: begin
        cmd.nb_rd   = st.nb_ok;
        cmd.nb_next = !st.nb_ok && !st.nb_last;
      end
      S_NB_CHK: begin
        cmd.nb_push = 1'b1;
        cmd.nb_next = !st.nb_last;
      end
      S_MARK: begin
        cmd.mark = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* hdl/gdr_dpath.sv */
module gdr_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cell_blocked,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            reachable,
  output logic                            stack_overflow,
  input  logic                            cfg_write,
  input  logic [gdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gdr_pkg::CFG_W-1:0]       cfg_data,
  input  gdr_pkg::gdr_cmd_t               cmd,
  output gdr_pkg::gdr_status_t            st
);
  import gdr_pkg::*;

  // Configuration.
  logic [DIM_W-1:0] grid_rows;
  logic [DIM_W-1:0] grid_cols;
  logic [ROW_W-1:0] start_row;
  logic [COL_W-1:0] start_col;
  logic [ROW_W-1:0] end_row;
  logic [COL_W-1:0] end_col;

  logic [DIM_W-1:0] rows_eff;
  logic [DIM_W-1:0] cols_eff;
  logic [TOT_W-1:0] total;

  // Search state.
  logic [IDX_W-1:0] load_count;
  logic [SP_W-1:0]  sp;
  logic [SP_W-1:0]  sp_dec;
  logic             overflow_seen;
  logic             start_blk;
  logic [1:0]       nb_sel;
  gdr_pos_t         cur;
  gdr_pos_t         start_pos;
  gdr_pos_t         end_pos;
  gdr_pos_t         nb_pos;
  logic             nb_ok;
  gdr_pos_t         addr_pos;
  logic [IDX_W-1:0] rc_idx;

  // Memories.
  gdr_cell_t cell_mem [CELLS];
  gdr_cell_t mem_rdata;
  gdr_pos_t  stack_mem [STACK_DEPTH];
  gdr_pos_t  stack_rdata;

  logic         nb_take;
  logic         stack_full;
  logic         push_en;
  gdr_pos_t     push_pos;
  logic [SADDR_W-1:0] pop_addr;

  always_comb begin
    if (grid_rows == '0)                       rows_eff = DIM_W'(1);
    else if (grid_rows > DIM_W'(MAX_ROWS))     rows_eff = DIM_W'(MAX_ROWS);
    else                                       rows_eff = grid_rows;
    if (grid_cols == '0)                       cols_eff = DIM_W'(1);
    else if (grid_cols > DIM_W'(MAX_COLS))     cols_eff = DIM_W'(MAX_COLS);
    else                                       cols_eff = grid_cols;
  end

  assign total     = {{DIM_W{1'b0}}, rows_eff} * {{DIM_W{1'b0}}, cols_eff};
  assign start_pos = '{row: start_row, col: start_col};
  assign end_pos   = '{row: end_row, col: end_col};

  // Neighbor of the current cell in the selected direction.
  always_comb begin
    nb_pos = cur;
    nb_ok  = 1'b0;
    unique case (nb_sel)
      DIR_LEFT: begin
        nb_ok      = cur.col != '0;
        nb_pos.col = cur.col - 1'b1;
      end
      DIR_RIGHT: begin
        nb_ok      = (DIM_W'(cur.col) + DIM_W'(1)) < cols_eff;
        nb_pos.col = cur.col + 1'b1;
      end
      DIR_UP: begin
        nb_ok      = cur.row != '0;
        nb_pos.row = cur.row - 1'b1;
      end
      DIR_DOWN: begin
        nb_ok      = (DIM_W'(cur.row) + DIM_W'(1)) < rows_eff;
        nb_pos.row = cur.row + 1'b1;
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.rd_start) addr_pos = start_pos;
    else if (cmd.rd_end)       addr_pos = end_pos;
    else if (cmd.latch_cur)    addr_pos = stack_rdata;
    else if (cmd.nb_rd)        addr_pos = nb_pos;
    else                       addr_pos = cur;
  end

  assign rc_idx = cell_index(addr_pos, cols_eff);

  // Loading a cell also clears its visited mark, so every cell of the grid
  // starts each search unvisited.
  always_ff @(posedge clk) begin
    if (cmd.load_cell) begin
      cell_mem[load_count] <= {cell_blocked, 1'b0};
    end else if (cmd.mark) begin
      cell_mem[rc_idx] <= {1'b0, 1'b1};
    end
    mem_rdata <= cell_mem[rc_idx];
  end

  assign nb_take    = !mem_rdata.blocked && !mem_rdata.visited;
  assign stack_full = sp == SP_W'(STACK_DEPTH);
  assign push_en    = cmd.push_start || (cmd.nb_push && nb_take && !stack_full);
  assign push_pos   = cmd.push_start ? start_pos : nb_pos;
  assign sp_dec     = sp - 1'b1;
  assign pop_addr   = sp_dec[SADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[sp[SADDR_W-1:0]] <= push_pos;
    end
    stack_rdata <= stack_mem[pop_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows     <= DIM_W'(32);
      grid_cols     <= DIM_W'(32);
      start_row     <= '0;
      start_col     <= '0;
      end_row       <= '0;
      end_col       <= '0;
      load_count    <= '0;
      sp            <= '0;
      overflow_seen <= 1'b0;
      nb_sel        <= DIR_LEFT;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GRID_ROWS: grid_rows <= cfg_data;
          REG_GRID_COLS: grid_cols <= cfg_data;
          REG_START_ROW: start_row <= cfg_data[ROW_W-1:0];
          REG_START_COL: start_col <= cfg_data[COL_W-1:0];
          REG_END_ROW:   end_row   <= cfg_data[ROW_W-1:0];
          REG_END_COL:   end_col   <= cfg_data[COL_W-1:0];
          default: begin
          end
        endcase
      end

      if (cmd.load_cell) begin
        load_count <= st.last_cell ? '0 : load_count + 1'b1;
      end

      if (cmd.search_init) begin
        sp <= '0;
      end else if (push_en) begin
        sp <= sp + 1'b1;
      end else if (cmd.pop) begin
        sp <= sp_dec;
      end

      if (cmd.search_init) begin
        overflow_seen <= 1'b0;
      end else if (cmd.nb_push && nb_take && stack_full) begin
        overflow_seen <= 1'b1;
      end

      if (cmd.nb_first) begin
        nb_sel <= DIR_LEFT;
      end else if (cmd.nb_next) begin
        nb_sel <= nb_sel + 1'b1;
      end

      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_end) begin
      start_blk <= mem_rdata.blocked;
    end
    if (cmd.latch_cur) begin
      cur <= stack_rdata;
    end
    if (cmd.finish) begin
      reachable      <= cmd.finish_reach;
      stack_overflow <= overflow_seen;
    end
  end

  always_comb begin
    st.last_cell    = (TOT_W'(load_count) + TOT_W'(1)) >= total;
    st.out_busy     = out_valid;
    st.in_range     = (DIM_W'(start_row) < rows_eff) && (DIM_W'(start_col) < cols_eff)
                   && (DIM_W'(end_row) < rows_eff) && (DIM_W'(end_col) < cols_eff);
    st.ends_blocked = start_blk || mem_rdata.blocked;
    st.stack_empty  = sp == '0;
    st.cur_visited  = mem_rdata.visited;
    st.cur_is_end   = (cur.row == end_row) && (cur.col == end_col);
    st.nb_ok        = nb_ok;
    st.nb_last      = nb_sel == DIR_DOWN;
  end

endmodule
